/* hw/rtl/leb_pkg.sv */
`timescale 1ns / 1ps

package leb_pkg;

  localparam int MAX_CHARS = 64;
  localparam int ADDR_W    = $clog2(MAX_CHARS);
  localparam int CNT_W     = $clog2(MAX_CHARS + 1);

  // request codes
  localparam logic [3:0] REQ_CHAR      = 4'd0;
  localparam logic [3:0] REQ_LEFT      = 4'd1;
  localparam logic [3:0] REQ_RIGHT     = 4'd2;
  localparam logic [3:0] REQ_DELETE    = 4'd3;
  localparam logic [3:0] REQ_BACKSPACE = 4'd4;
  localparam logic [3:0] REQ_ENTER     = 4'd5;
  localparam logic [3:0] REQ_ESCAPE    = 4'd6;
  localparam logic [3:0] REQ_HOME      = 4'd7;
  localparam logic [3:0] REQ_END       = 4'd8;

  // result kinds
  localparam logic [1:0] KIND_STATUS = 2'd0;
  localparam logic [1:0] KIND_CHAR   = 2'd1;
  localparam logic [1:0] KIND_EMPTY  = 2'd2;

  // character codes that insert nothing
  localparam logic [8:0] CODE_NUL  = 9'h000;
  localparam logic [8:0] CODE_NL   = 9'h00A;
  localparam logic [8:0] CODE_NONE = 9'h1FF;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [7:0]        wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } leb_mem_req_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [7:0]       char_out;
    logic [CNT_W-1:0] cursor;
    logic [CNT_W-1:0] length;
    logic             last;
  } leb_res_t;

endpackage

/* hw/rtl/leb_mem.sv */
`timescale 1ns / 1ps

module leb_mem
  import leb_pkg::*;
(
  input  logic         clk_i,
  input  leb_mem_req_t req_i,
  output logic [7:0]   rdata_o
);

  logic [7:0] mem_q [MAX_CHARS];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/leb_ctrl.sv */
`timescale 1ns / 1ps

module leb_ctrl
  import leb_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [3:0]        req_type_i,
  input  logic signed [8:0] char_code_i,
  output leb_mem_req_t      mem_req_o,
  input  logic [7:0]        mem_rdata_i,
  output logic              res_valid_o,
  input  logic              res_ready_i,
  output leb_res_t          res_o
);

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_MOVE    = 3'd1;
  localparam logic [2:0] ST_RESP    = 3'd2;
  localparam logic [2:0] ST_EMIT_RD = 3'd3;
  localparam logic [2:0] ST_EMIT_WT = 3'd4;

  logic [2:0]        state_q, state_d;
  logic [CNT_W-1:0]  cur_q, cur_d;
  logic [CNT_W-1:0]  len_q, len_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [ADDR_W-1:0] src_q, src_d;
  logic [ADDR_W-1:0] raddr_q;
  logic              pend_q, pend_d;
  logic              ins_q, ins_d;
  logic [7:0]        byte_q, byte_d;
  logic [1:0]        kind_q, kind_d;
  logic [8:0]        code;
  logic              code_ok;
  logic              emit_last;

  assign code      = $unsigned(char_code_i);
  assign code_ok   = (code != CODE_NUL) && (code != CODE_NL) && (code != CODE_NONE);
  assign emit_last = (CNT_W'(src_q) + CNT_W'(1)) == cnt_q;

  assign in_stall_o = (state_q != ST_IDLE);

  always_comb begin
    state_d     = state_q;
    cur_d       = cur_q;
    len_d       = len_q;
    cnt_d       = cnt_q;
    src_d       = src_q;
    pend_d      = 1'b0;
    ins_d       = ins_q;
    byte_d      = byte_q;
    kind_d      = kind_q;
    mem_req_o   = '0;
    res_valid_o = 1'b0;
    res_o       = '{kind: kind_q, char_out: 8'd0, cursor: cur_q, length: len_q, last: 1'b1};

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          kind_d  = KIND_STATUS;
          state_d = ST_RESP;
          case (req_type_i)
            REQ_LEFT: begin
              cur_d = (cur_q == '0) ? len_q : cur_q - CNT_W'(1);
            end
            REQ_RIGHT: begin
              cur_d = (cur_q >= len_q) ? '0 : cur_q + CNT_W'(1);
            end
            REQ_DELETE: begin
              if (cur_q < len_q) begin
                ins_d   = 1'b0;
                cnt_d   = len_q - cur_q - CNT_W'(1);
                src_d   = ADDR_W'(cur_q + CNT_W'(1));
                state_d = ST_MOVE;
              end
            end
            REQ_BACKSPACE: begin
              if (cur_q != '0) begin
                ins_d   = 1'b0;
                cur_d   = cur_q - CNT_W'(1);
                cnt_d   = len_q - cur_q;
                src_d   = ADDR_W'(cur_q);
                state_d = ST_MOVE;
              end
            end
            REQ_ENTER: begin
              cur_d = '0;
              len_d = '0;
              if (len_q == '0) begin
                kind_d = KIND_EMPTY;
              end else begin
                cnt_d   = len_q;
                src_d   = '0;
                state_d = ST_EMIT_RD;
              end
            end
            REQ_ESCAPE: begin
              cur_d = '0;
              len_d = '0;
            end
            REQ_HOME: begin
              cur_d = '0;
            end
            REQ_END: begin
              cur_d = len_q;
            end
            default: begin
              // character key, also unused request codes
              if (code_ok && (len_q != CNT_W'(MAX_CHARS))) begin
                ins_d   = 1'b1;
                byte_d  = code[7:0];
                cnt_d   = len_q - cur_q;
                src_d   = ADDR_W'(len_q - CNT_W'(1));
                state_d = ST_MOVE;
              end
            end
          endcase
        end
      end

      ST_MOVE: begin
        // write back the byte read last cycle one place over
        if (pend_q) begin
          mem_req_o.we    = 1'b1;
          mem_req_o.waddr = ins_q ? raddr_q + ADDR_W'(1) : raddr_q - ADDR_W'(1);
          mem_req_o.wdata = mem_rdata_i;
        end
        if (cnt_q != '0) begin
          mem_req_o.re    = 1'b1;
          mem_req_o.raddr = src_q;
          src_d           = ins_q ? src_q - ADDR_W'(1) : src_q + ADDR_W'(1);
          cnt_d           = cnt_q - CNT_W'(1);
          pend_d          = 1'b1;
        end else if (!pend_q) begin
          if (ins_q) begin
            mem_req_o.we    = 1'b1;
            mem_req_o.waddr = ADDR_W'(cur_q);
            mem_req_o.wdata = byte_q;
            cur_d           = cur_q + CNT_W'(1);
            len_d           = len_q + CNT_W'(1);
          end else begin
            len_d = len_q - CNT_W'(1);
          end
          state_d = ST_RESP;
        end
      end

      ST_RESP: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end

      ST_EMIT_RD: begin
        mem_req_o.re    = 1'b1;
        mem_req_o.raddr = src_q;
        state_d         = ST_EMIT_WT;
      end

      ST_EMIT_WT: begin
        res_valid_o    = 1'b1;
        res_o.kind     = KIND_CHAR;
        res_o.char_out = mem_rdata_i;
        res_o.last     = emit_last;
        if (res_ready_i) begin
          src_d   = src_q + ADDR_W'(1);
          state_d = emit_last ? ST_IDLE : ST_EMIT_RD;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cur_q   <= '0;
      len_q   <= '0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cur_q   <= cur_d;
      len_q   <= len_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q  <= cnt_d;
    src_q  <= src_d;
    ins_q  <= ins_d;
    byte_q <= byte_d;
    kind_q <= kind_d;
    if (mem_req_o.re) begin
      raddr_q <= mem_req_o.raddr;
    end
  end

`ifndef SYNTHESIS
  a_len_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= CNT_W'(MAX_CHARS))
    else $error("line length above capacity");

  a_cur_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_q <= len_q)
    else $error("cursor beyond end of line");

  a_rw_apart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_req_o.we && mem_req_o.re) |-> (mem_req_o.waddr != mem_req_o.raddr))
    else $error("read and write hit the same entry");

  a_move_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MOVE && cnt_q == '0 && !pend_q) |=> (state_q == ST_RESP))
    else $error("shift did not finish");

  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_ready_i && res_o.last) |=> (state_q == ST_IDLE))
    else $error("final result did not return to idle");
`endif

endmodule

/* hw/rtl/line_edit_buffer.sv */
`timescale 1ns / 1ps

// One-line text editor with a cursor, the line held in a 64-byte memory.
// Input channel: in_valid_i / in_stall_o carry one key event per beat
// (req_type_i, char_code_i). Output channel: out_valid_o / out_stall_i carry
// result beats (kind_o, char_out_o, cursor_o, length_o, last_o).
// Cursor moves, home, end and escape load one status beat into the output
// register from the response state, once that register is free.
// Insert, delete and backspace shift the tail through the memory one byte
// per cycle, reading each byte and writing it one place over; the bytes
// shifted number length - cursor, one fewer for delete, then a status beat.
// Enter reads the line back one beat per character, via a read and a wait
// state, last_o marking the last; an empty line gives one empty-line beat.
// A new event is taken at the edge after the previous event's final beat
// lands in the output register, even if that beat is still stalled.
// out_stall_i holds the output register and, behind it, the sequencer; no
// beat is lost or repeated. Reset clears cursor and length; the memory
// itself is not cleared and needs no clearing pass, since only bytes below
// the length are ever read.
module line_edit_buffer
  import leb_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [3:0]        req_type_i,
  input  logic signed [8:0] char_code_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [1:0]        kind_o,
  output logic [7:0]        char_out_o,
  output logic [6:0]        cursor_o,
  output logic [6:0]        length_o,
  output logic              last_o
);

  leb_mem_req_t mem_req;
  logic [7:0]   mem_rdata;
  logic         res_valid;
  logic         res_ready;
  leb_res_t     res;
  logic         out_valid_q;
  leb_res_t     out_res_q;

  leb_mem u_mem (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  leb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .req_type_i  (req_type_i),
    .char_code_i (char_code_i),
    .mem_req_o   (mem_req),
    .mem_rdata_i (mem_rdata),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  // output register frees up in the cycle its beat is taken
  assign res_ready = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_res_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign kind_o      = out_res_q.kind;
  assign char_out_o  = out_res_q.char_out;
  assign cursor_o    = 7'(out_res_q.cursor);
  assign length_o    = 7'(out_res_q.length);
  assign last_o      = out_res_q.last;

endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
  import leb_pkg::*;

  // Generous: every event a full 64-beat submit with long output stalls.
  localparam int unsigned CYCLE_LIMIT = 3_000_000;
  // Longest single event: a submit of the whole line, one beat per character.
  localparam int unsigned DRAIN_CYCLES = 200;
  localparam int unsigned PHASE_ITEMS = 117;

  class line_scoreboard;
    logic [7:0]  line_buf [MAX_CHARS];
    int unsigned cur_pos;
    int unsigned line_len;
    leb_res_t    pending_q[$];
    int unsigned fails;

    function new();
      cur_pos  = 0;
      line_len = 0;
      fails    = 0;
    endfunction

    function void push_beat(logic [1:0] kind, logic [7:0] ch, logic last);
      leb_res_t b;
      b.kind     = kind;
      b.char_out = ch;
      b.cursor   = CNT_W'(cur_pos);
      b.length   = CNT_W'(line_len);
      b.last     = last;
      pending_q.push_back(b);
    endfunction

    function void drop_at(int unsigned pos);
      if (pos >= line_len) return;
      for (int unsigned i = pos; i + 1 < line_len; i++) line_buf[i] = line_buf[i + 1];
      line_len--;
    endfunction

    // Advance the line model by one accepted key event.
    function void note_event(logic [3:0] req, logic [8:0] code);
      int unsigned n;
      case (req)
        REQ_LEFT: cur_pos = (cur_pos == 0) ? line_len : cur_pos - 1;
        REQ_RIGHT: cur_pos = (cur_pos >= line_len) ? 0 : cur_pos + 1;
        REQ_DELETE: drop_at(cur_pos);
        REQ_BACKSPACE: begin
          if (cur_pos > 0) begin
            cur_pos--;
            drop_at(cur_pos);
          end
        end
        REQ_ENTER: begin
          n        = line_len;
          line_len = 0;
          cur_pos  = 0;
          if (n == 0) begin
            push_beat(KIND_EMPTY, 8'h00, 1'b1);
          end else begin
            for (int unsigned i = 0; i < n; i++)
              push_beat(KIND_CHAR, line_buf[i], i + 1 == n);
          end
          return;
        end
        REQ_ESCAPE: begin
          line_len = 0;
          cur_pos  = 0;
        end
        REQ_HOME: cur_pos = 0;
        REQ_END: cur_pos = line_len;
        default: begin
          // unused request codes behave as a character key
          if (code != CODE_NUL && code != CODE_NL && code != CODE_NONE &&
              line_len < MAX_CHARS) begin
            for (int unsigned i = line_len; i > cur_pos; i--) line_buf[i] = line_buf[i - 1];
            line_buf[cur_pos] = code[7:0];
            line_len++;
            cur_pos++;
          end
        end
      endcase
      push_beat(KIND_STATUS, 8'h00, 1'b1);
    endfunction

    function void check_beat(leb_res_t got);
      leb_res_t want;
      if (pending_q.size() == 0) begin
        $error("unexpected result beat: kind %0d char %0d cursor %0d length %0d last %0d",
               got.kind, got.char_out, got.cursor, got.length, got.last);
        fails++;
        return;
      end
      want = pending_q.pop_front();
      if (got.kind != want.kind) begin
        $error("kind: expected %0d, got %0d", want.kind, got.kind);
        fails++;
      end
      if (got.char_out != want.char_out) begin
        $error("char_out: expected %0d, got %0d", want.char_out, got.char_out);
        fails++;
      end
      if (got.cursor != want.cursor) begin
        $error("cursor: expected %0d, got %0d", want.cursor, got.cursor);
        fails++;
      end
      if (got.length != want.length) begin
        $error("length: expected %0d, got %0d", want.length, got.length);
        fails++;
      end
      if (got.last != want.last) begin
        $error("last: expected %0d, got %0d", want.last, got.last);
        fails++;
      end
    endfunction
  endclass

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              in_valid_i  = 1'b0;
  logic              in_stall_o;
  logic [3:0]        req_type_i  = REQ_CHAR;
  logic signed [8:0] char_code_i = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [1:0]        kind_o;
  logic [7:0]        char_out_o;
  logic [6:0]        cursor_o;
  logic [6:0]        length_o;
  logic              last_o;

  line_scoreboard line_sb = new();
  int unsigned    in_idle_pct   = 0;
  int unsigned    out_stall_pct = 0;
  int unsigned    events_sent   = 0;
  int unsigned    cycle_cnt     = 0;

  line_edit_buffer dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .req_type_i  (req_type_i),
    .char_code_i (char_code_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .kind_o      (kind_o),
    .char_out_o  (char_out_o),
    .cursor_o    (cursor_o),
    .length_o    (length_o),
    .last_o      (last_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Output side: check each accepted beat, then pick the next stall.
  always @(posedge clk_i) begin
    leb_res_t got;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.kind     = kind_o;
      got.char_out = char_out_o;
      got.cursor   = cursor_o;
      got.length   = length_o;
      got.last     = last_o;
      line_sb.check_beat(got);
    end
    out_stall_i <= ($urandom_range(99) < out_stall_pct);
  end

  // Call at a rising edge; returns at the edge where the beat was taken.
  task automatic send_event(input logic [3:0] req, input logic [8:0] code);
    if ($urandom_range(99) < in_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < in_idle_pct);
    end
    in_valid_i  <= 1'b1;
    req_type_i  <= req;
    char_code_i <= code;
    do @(posedge clk_i); while (in_stall_o);
    line_sb.note_event(req, code);
    events_sent++;
  endtask

  function automatic logic [8:0] pick_code();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 70) return 9'($urandom_range(32, 126));
    if (r < 90) return 9'($urandom_range(511));
    case ($urandom_range(2))
      0: return CODE_NUL;
      1: return CODE_NL;
      default: return CODE_NONE;
    endcase
  endfunction

  task automatic run_directed();
    send_event(REQ_ENTER, 9'h000);       // submit of an empty line
    send_event(REQ_DELETE, 9'h000);      // delete at end
    send_event(REQ_BACKSPACE, 9'h000);   // backspace at 0
    send_event(REQ_LEFT, 9'h000);
    send_event(REQ_RIGHT, 9'h000);
    send_event(REQ_CHAR, CODE_NUL);
    send_event(REQ_CHAR, CODE_NL);
    send_event(REQ_CHAR, CODE_NONE);
    send_event(REQ_CHAR, 9'h041);
    send_event(REQ_CHAR, 9'h0FF);
    send_event(REQ_CHAR, 9'h1FE);        // -2 keeps its low byte
    send_event(REQ_CHAR, 9'h100);        // -256 stores a zero byte
    send_event(4'd9, 9'h001);            // unused codes insert like a key
    send_event(4'd15, 9'h07E);
    send_event(REQ_HOME, 9'h000);
    send_event(REQ_RIGHT, 9'h000);
    send_event(REQ_DELETE, 9'h000);
    send_event(REQ_LEFT, 9'h000);
    send_event(REQ_LEFT, 9'h000);        // wrap to the end
    send_event(REQ_RIGHT, 9'h000);       // wrap to 0
    send_event(REQ_END, 9'h000);
    send_event(REQ_BACKSPACE, 9'h000);
    send_event(REQ_ENTER, 9'h000);
    send_event(REQ_CHAR, 9'h078);
    send_event(REQ_ESCAPE, 9'h000);
  endtask

  // Type and edit a line, then submit or discard it; some sessions overfill it.
  task automatic run_session();
    bit          fill;
    int unsigned n_keys;
    int unsigned char_pct;
    int unsigned r;
    logic [3:0]  req;
    logic [8:0]  code;
    fill     = ($urandom_range(7) == 0);
    n_keys   = fill ? $urandom_range(66, 80) : $urandom_range(1, 20);
    char_pct = fill ? 95 : 60;
    for (int unsigned k = 0; k < n_keys; k++) begin
      r    = $urandom_range(99);
      code = 9'($urandom_range(511));
      if (r < char_pct) begin
        req  = REQ_CHAR;
        code = pick_code();
      end else if (r < char_pct + 3) begin
        req  = 4'($urandom_range(9, 15));
        code = pick_code();
      end else begin
        case ($urandom_range(7))
          0: req = REQ_LEFT;
          1: req = REQ_RIGHT;
          2: req = REQ_DELETE;
          3: req = REQ_BACKSPACE;
          4: req = REQ_HOME;
          5: req = REQ_END;
          6: req = REQ_LEFT;
          default: req = $urandom_range(1) ? REQ_ENTER : REQ_ESCAPE;
        endcase
      end
      send_event(req, code);
    end
    send_event(($urandom_range(4) == 0) ? REQ_ESCAPE : REQ_ENTER, 9'($urandom_range(511)));
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          in_idle_pct   = 15;
          out_stall_pct = 73;
        end
        1: begin
          in_idle_pct   = 73;
          out_stall_pct = 15;
        end
        default: begin
          in_idle_pct   = 0;
          out_stall_pct = 0;
        end
      endcase
      if (ph == 0) run_directed();
      while (events_sent < PHASE_ITEMS * (ph + 1)) run_session();
    end
    in_valid_i <= 1'b0;
    while (line_sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (line_sb.fails == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule
